>>> sv/decimating_complex_fir_core_defines.svh
// Assertion macros shared by the checker files of the decimating complex FIR.
// Needs signals named clk and rst_n in the scope where a macro is used.
`ifndef DECIMATING_COMPLEX_FIR_CORE_DEFINES_SVH
`define DECIMATING_COMPLEX_FIR_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define DCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define DCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/dcf_pkg.sv
// Shared constants and control types of the decimating complex FIR.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package dcf_pkg;

  // parameter defaults
  localparam int MAX_TAPS_DEF     = 64;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int TAP_WIDTH_DEF    = 16;

  // fixed field and register widths
  localparam int CFG_W     = 7;
  localparam int TAP_IDX_W = 6;
  localparam int PHASE_W   = 6;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // decimation limits and register reset values
  localparam logic [CFG_W-1:0] DECIM_MIN   = 7'd2;
  localparam logic [CFG_W-1:0] DECIM_MAX   = 7'd64;
  localparam logic [CFG_W-1:0] DECIM_RESET = 7'd2;
  localparam logic [CFG_W-1:0] TAPS_RESET  = 7'd64;

  // register select (address bit 2)
  localparam logic REG_DECIMATION = 1'b0;
  localparam logic REG_TAP_COUNT  = 1'b1;

  // item operations
  localparam logic OP_SAMPLE   = 1'b0;
  localparam logic OP_TAP_LOAD = 1'b1;

  // controls broadcast to every cell of the ring
  typedef struct packed {
    logic shift;     // new sample enters cell 0, history moves up
    logic rotate;    // ring turns by one towards cell 0
    logic tap_load;  // one cell takes tap_value
  } ring_ctrl_t;

  // controls of the shared multiply-accumulate unit
  typedef struct packed {
    logic clear;     // start a new sum
    logic mul_en;    // register the product of cell 0
    logic acc_en;    // add the registered product
    logic keep;      // current product lies inside the tap count
  } mac_ctrl_t;

endpackage

>>> sv/decimating_complex_fir_core.sv
// Channel  Ports                                          Handshake
// input    in_operation, in_sample_re/im, in_tap_*        in_valid / in_stall
// result   out_re, out_im                                 out_valid / out_stall
// config   psel, penable, pwrite, paddr, pwdata, prdata   pready (always high)
//
// A tap load or a sample that gives no output is taken without stalling the input.
// A sample that gives an output stalls the input through S_RUN, S_LAST and S_OUT;
// in S_RUN the ring turns once round through the single shared multiply-accumulate unit.
// Reset clears the sample history in the cells at once; taps are undefined until loaded.
// A finished result waits in the output register; a stalled result only holds up
// the next output sample at its final cycle.
//
// Top level of the decimating complex FIR. Depends on dcf_pkg, dcf_cell, dcf_mac.
`timescale 1ns / 1ps

module decimating_complex_fir_core import dcf_pkg::*; #(
  parameter int MAX_TAPS     = MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TAP_WIDTH    = TAP_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_operation,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample_im,
  input  logic        [TAP_IDX_W-1:0]    in_tap_index,
  input  logic signed [TAP_WIDTH-1:0]    in_tap_value,
  // result channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_re,
  output logic signed [SAMPLE_WIDTH-1:0] out_im,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic        [ADDR_W-1:0]       paddr,
  input  logic        [DATA_W-1:0]       pwdata,
  output logic        [DATA_W-1:0]       prdata,
  output logic                           pready
);

  localparam int STEP_W = $clog2(MAX_TAPS);
  localparam int NW     = ($clog2(MAX_TAPS + 1) > CFG_W) ? $clog2(MAX_TAPS + 1) : CFG_W;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(MAX_TAPS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RUN  = 4'b0010,
    S_LAST = 4'b0100,
    S_OUT  = 4'b1000
  } dcf_state_t;

  dcf_state_t                     state_r, state_nxt;
  logic        [STEP_W-1:0]       step_r, step_nxt;
  logic        [CFG_W-1:0]        decimation_r;
  logic        [CFG_W-1:0]        tap_count_r;
  logic        [PHASE_W-1:0]      phase_r, phase_nxt;
  logic        [CFG_W-1:0]        phase_inc;
  logic        [CFG_W-1:0]        d_eff;
  logic        [NW-1:0]           tc_ext;
  logic        [NW-1:0]           n_eff;
  logic                           in_accept;
  logic                           smp_accept;
  logic                           emit;
  logic                           cfg_write;
  logic                           slot_free;
  logic                           out_load;
  logic                           out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_re_r;
  logic signed [SAMPLE_WIDTH-1:0] out_im_r;
  logic signed [SAMPLE_WIDTH-1:0] res_re;
  logic signed [SAMPLE_WIDTH-1:0] res_im;
  ring_ctrl_t                     ring_ctrl;
  mac_ctrl_t                      mac_ctrl;

  logic signed [SAMPLE_WIDTH-1:0] smp_re   [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] smp_im   [MAX_TAPS];
  logic signed [TAP_WIDTH-1:0]    tap      [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] shift_re [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] shift_im [MAX_TAPS];

  // configuration registers
  assign cfg_write = psel && penable && pwrite && pready;
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decimation_r <= DECIM_RESET;
      tap_count_r  <= TAPS_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DECIMATION: decimation_r <= pwdata[CFG_W-1:0];
        REG_TAP_COUNT:  tap_count_r  <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_DECIMATION: prdata = DATA_W'(decimation_r);
      REG_TAP_COUNT:  prdata = DATA_W'(tap_count_r);
      default:        prdata = '0;
    endcase
  end

  // handshake
  assign in_stall   = (state_r != S_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign smp_accept = in_accept && (in_operation == OP_SAMPLE);

  // output phase, with decimation clamped to its legal range
  always_comb begin
    priority if (decimation_r < DECIM_MIN) begin
      d_eff = DECIM_MIN;
    end else if (decimation_r > DECIM_MAX) begin
      d_eff = DECIM_MAX;
    end else begin
      d_eff = decimation_r;
    end
  end

  assign emit      = (phase_r == '0);
  assign phase_inc = CFG_W'(phase_r) + CFG_W'(1);
  assign phase_nxt = (phase_inc >= d_eff) ? '0 : phase_inc[PHASE_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (smp_accept) begin
      phase_r <= phase_nxt;
    end
  end

  // taps in use: zero acts as one, clamp at the ring length
  assign tc_ext = NW'(tap_count_r);
  always_comb begin
    priority if (tc_ext == '0) begin
      n_eff = NW'(1);
    end else if (tc_ext > NW'(MAX_TAPS)) begin
      n_eff = NW'(MAX_TAPS);
    end else begin
      n_eff = tc_ext;
    end
  end

  // sequencer: one full turn of the ring per output
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    unique case (state_r)
      S_IDLE: begin
        if (smp_accept && emit) begin
          state_nxt = S_RUN;
          step_nxt  = '0;
        end
      end
      S_RUN: begin
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  // ring and MAC controls
  assign ring_ctrl.shift    = smp_accept;
  assign ring_ctrl.rotate   = (state_r == S_RUN);
  assign ring_ctrl.tap_load = in_accept && (in_operation == OP_TAP_LOAD);

  assign mac_ctrl.clear  = smp_accept && emit;
  assign mac_ctrl.mul_en = (state_r == S_RUN);
  assign mac_ctrl.acc_en = (state_r == S_RUN) || (state_r == S_LAST);
  assign mac_ctrl.keep   = (NW'(step_r) < n_eff);

  // chain of cells: cell 0 holds the newest sample
  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
    localparam int NEXT = (k + 1) % MAX_TAPS;

    if (k == 0) begin : g_head
      assign shift_re[k] = in_sample_re;
      assign shift_im[k] = in_sample_im;
    end else begin : g_body
      assign shift_re[k] = smp_re[k-1];
      assign shift_im[k] = smp_im[k-1];
    end

    dcf_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH),
      .TAP_WIDTH    (TAP_WIDTH),
      .INDEX        (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ring_ctrl),
      .tap_index (in_tap_index),
      .tap_value (in_tap_value),
      .shift_re  (shift_re[k]),
      .shift_im  (shift_im[k]),
      .rot_re    (smp_re[NEXT]),
      .rot_im    (smp_im[NEXT]),
      .rot_tap   (tap[NEXT]),
      .smp_re    (smp_re[k]),
      .smp_im    (smp_im[k]),
      .tap       (tap[k])
    );
  end

  // shared multiply-accumulate on cell 0
  dcf_mac #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TAP_WIDTH    (TAP_WIDTH),
    .MAX_TAPS     (MAX_TAPS)
  ) u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .x_re   (smp_re[0]),
    .x_im   (smp_im[0]),
    .tap    (tap[0]),
    .res_re (res_re),
    .res_im (res_im)
  );

  // output register
  assign slot_free = !out_valid_r || !out_stall;
  assign out_load  = (state_r == S_OUT) && slot_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_re_r <= res_re;
      out_im_r <= res_im;
    end
  end

  assign out_valid = out_valid_r;
  assign out_re    = out_re_r;
  assign out_im    = out_im_r;

endmodule

>>> sv/dcf_cell.sv
// One ring cell: holds one complex history sample and one tap coefficient.
// Depends on dcf_pkg.
`timescale 1ns / 1ps

module dcf_cell import dcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TAP_WIDTH    = TAP_WIDTH_DEF,
  parameter int INDEX        = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ring_ctrl_t                     ctrl,
  input  logic        [TAP_IDX_W-1:0]    tap_index,
  input  logic signed [TAP_WIDTH-1:0]    tap_value,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_re,
  input  logic signed [SAMPLE_WIDTH-1:0] shift_im,
  input  logic signed [SAMPLE_WIDTH-1:0] rot_re,
  input  logic signed [SAMPLE_WIDTH-1:0] rot_im,
  input  logic signed [TAP_WIDTH-1:0]    rot_tap,
  output logic signed [SAMPLE_WIDTH-1:0] smp_re,
  output logic signed [SAMPLE_WIDTH-1:0] smp_im,
  output logic signed [TAP_WIDTH-1:0]    tap
);

  logic signed [SAMPLE_WIDTH-1:0] re_r;
  logic signed [SAMPLE_WIDTH-1:0] im_r;
  logic signed [TAP_WIDTH-1:0]    tap_r;
  logic                           load;

  // this cell's tap position addressed
  assign load = ctrl.tap_load && (int'(tap_index) == INDEX);

  // sample history: zero from reset; shift and rotate never coincide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      re_r <= '0;
      im_r <= '0;
    end else begin
      if (ctrl.shift) begin
        re_r <= shift_re;
        im_r <= shift_im;
      end else if (ctrl.rotate) begin
        re_r <= rot_re;
        im_r <= rot_im;
      end
    end
  end

  // coefficient: undefined until loaded; loads only while the ring is still
  always_ff @(posedge clk) begin
    if (load) begin
      tap_r <= tap_value;
    end else if (ctrl.rotate) begin
      tap_r <= rot_tap;
    end
  end

  assign smp_re = re_r;
  assign smp_im = im_r;
  assign tap    = tap_r;

endmodule

>>> sv/dcf_mac.sv
// Shared complex-by-real multiply-accumulate with round and saturate.
// Depends on dcf_pkg.
`timescale 1ns / 1ps

module dcf_mac import dcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int TAP_WIDTH    = TAP_WIDTH_DEF,
  parameter int MAX_TAPS     = MAX_TAPS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mac_ctrl_t                      ctrl,
  input  logic signed [SAMPLE_WIDTH-1:0] x_re,
  input  logic signed [SAMPLE_WIDTH-1:0] x_im,
  input  logic signed [TAP_WIDTH-1:0]    tap,
  output logic signed [SAMPLE_WIDTH-1:0] res_re,
  output logic signed [SAMPLE_WIDTH-1:0] res_im
);

  localparam int PW = SAMPLE_WIDTH + TAP_WIDTH;
  localparam int AW = PW + $clog2(MAX_TAPS);

  localparam logic signed [AW-1:0] RND_HALF = AW'(64'sd1 <<< (TAP_WIDTH - 2));
  localparam logic signed [AW-1:0] SAT_HI   = AW'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
  localparam logic signed [AW-1:0] SAT_LO   = AW'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

  logic signed [PW-1:0] prod_re_r;
  logic signed [PW-1:0] prod_im_r;
  logic                 prod_ok_r;
  logic signed [AW-1:0] acc_re_r;
  logic signed [AW-1:0] acc_im_r;

  // round half up to the sample format, then clamp
  function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(input logic signed [AW-1:0] a);
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] shf;
    rnd = a + RND_HALF;
    shf = rnd >>> (TAP_WIDTH - 1);
    if (shf > SAT_HI) begin
      return SAT_HI[SAMPLE_WIDTH-1:0];
    end else if (shf < SAT_LO) begin
      return SAT_LO[SAMPLE_WIDTH-1:0];
    end
    return shf[SAMPLE_WIDTH-1:0];
  endfunction

  // product stage
  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_re_r <= tap * x_re;
      prod_im_r <= tap * x_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_ok_r <= 1'b0;
    end else if (ctrl.clear) begin
      prod_ok_r <= 1'b0;
    end else if (ctrl.mul_en) begin
      prod_ok_r <= ctrl.keep;
    end
  end

  // accumulate stage
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (ctrl.acc_en && prod_ok_r) begin
      acc_re_r <= acc_re_r + AW'(prod_re_r);
      acc_im_r <= acc_im_r + AW'(prod_im_r);
    end
  end

  assign res_re = round_sat(acc_re_r);
  assign res_im = round_sat(acc_im_r);

endmodule

>>> sv/dcf_checker.sv
// Port-level checks of the decimating complex FIR, bound to the top level.
// Depends on dcf_pkg and decimating_complex_fir_core_defines.svh.
`timescale 1ns / 1ps
`include "decimating_complex_fir_core_defines.svh"

module dcf_checker import dcf_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_stall,
  input logic                    in_operation,
  input logic                    out_valid,
  input logic                    out_stall,
  input logic [SAMPLE_WIDTH-1:0] out_re,
  input logic [SAMPLE_WIDTH-1:0] out_im
);

  // a held result keeps its value
  `DCF_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_re) && $stable(out_im), "result changed while stalled")

  // a tap load never yields a result
  `DCF_ASSERT_NEXT(a_load_silent, in_valid && !in_stall && (in_operation == OP_TAP_LOAD) && !out_valid, !out_valid, "result after tap load")

  // busy only after taking a sample item
  `DCF_ASSERT_NOW(a_busy_cause, $rose(in_stall), $past(in_valid) && $past(in_operation == OP_SAMPLE), "stall without a sample item")

  // a new result only appears at the end of a busy spell
  `DCF_ASSERT_NOW(a_out_from_busy, $rose(out_valid), $past(in_stall), "result without computation")

endmodule

bind decimating_complex_fir_core dcf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dcf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_operation (in_operation),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_re       (out_re),
  .out_im       (out_im)
);
